[rtl/core/idbs_pkg.sv]
`default_nettype none

package idbs_pkg;

  localparam int TIMER_BITS = 20;
  localparam int SECS_W     = 20;
  localparam int LOAD_W     = 7;

  typedef logic [1:0]            mode_t;
  typedef logic [1:0]            cmd_t;
  typedef logic [1:0]            phase_t;
  typedef logic [1:0]            cfg_index_t;
  typedef logic [SECS_W-1:0]     secs_t;
  typedef logic [LOAD_W-1:0]     load_t;
  typedef logic [TIMER_BITS-1:0] count_t;

  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_DIM    = 2'd1;
  localparam mode_t MODE_BLANK  = 2'd2;
  localparam mode_t MODE_SLEEP  = 2'd3;

  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_ACTIVE = 2'd1;
  localparam cmd_t CMD_IDLE   = 2'd2;
  localparam cmd_t CMD_REEVAL = 2'd3;

  localparam phase_t PH_UNARMED  = 2'd0;
  localparam phase_t PH_COUNTING = 2'd1;
  localparam phase_t PH_SPENT    = 2'd2;

  localparam cfg_index_t CFG_BLANK_SECONDS = 2'd0;
  localparam cfg_index_t CFG_SLEEP_SECONDS = 2'd1;
  localparam cfg_index_t CFG_CHECK_CPU     = 2'd2;
  localparam cfg_index_t CFG_BUSY_LIMIT    = 2'd3;

  localparam secs_t RESET_BLANK_SECONDS = 20'd1048575;
  localparam secs_t RESET_SLEEP_SECONDS = 20'd1048575;
  localparam load_t RESET_BUSY_LIMIT    = 7'd5;

  typedef struct packed {
    secs_t blank_seconds;
    secs_t sleep_seconds;
    logic  check_cpu_enable;
    load_t cpu_busy_limit;
  } idbs_cfg_t;

  typedef struct packed {
    mode_t  mode;
    logic   user_idle;
    phase_t blank_phase;
    count_t blank_rem;
    phase_t sleep_phase;
    count_t sleep_rem;
  } idbs_state_t;

  typedef struct packed {
    logic session_quiet;
    logic idle_blocked;
    logic sleep_blocked;
  } idbs_flags_t;

  function automatic count_t load_counter(secs_t secs);
    logic [32:0] v;
    logic [32:0] lim;
    begin
      v   = 33'(secs);
      lim = (33'd1 << TIMER_BITS) - 33'd1;
      return count_t'((v > lim) ? lim : v);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/idle_dim_blank_sleep_controller.sv]
// Idle mode controller: each accepted transaction (a one-second tick, a user
// event or a re-evaluate command) updates the mode and the blank and sleep
// counters in the cycle it is accepted, so one transaction is taken every
// clock cycle while item_stall is low. Its result (mode after the
// transaction and a changed flag) goes to the output register, or to a
// one-entry skid stage behind it while a result is stalled; the skid entry
// lets one further transaction in, and item_stall rises only when it is
// occupied. Timeouts written through the configuration port take effect at
// the next arming, so the host should send a re-evaluate after changing them.
`default_nettype none

module idle_dim_blank_sleep_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  idbs_pkg::cfg_index_t cfg_index,
  input  idbs_pkg::secs_t      cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  idbs_pkg::cmd_t       command,
  input  logic                 session_quiet,
  input  logic                 idle_blocked,
  input  logic                 sleep_blocked,
  input  idbs_pkg::load_t      cpu_load,
  output logic                 result_valid,
  input  logic                 result_stall,
  output idbs_pkg::mode_t      mode_now,
  output logic                 mode_changed
);
  import idbs_pkg::*;

  idbs_cfg_t   cfg;
  idbs_state_t state;
  idbs_state_t state_next;
  idbs_flags_t flags;
  logic        item_accept;
  logic        result_taken;
  logic        skid_valid;
  mode_t       skid_mode;
  logic        skid_changed;
  mode_t       new_mode;
  logic        new_changed;

  assign flags = '{session_quiet: session_quiet,
                   idle_blocked:  idle_blocked,
                   sleep_blocked: sleep_blocked};

  idbs_eval u_eval (
    .state_cur  (state),
    .cfg        (cfg),
    .command    (command),
    .flags      (flags),
    .cpu_load   (cpu_load),
    .state_next (state_next)
  );

  assign item_stall   = skid_valid;
  assign item_accept  = item_valid && !skid_valid;
  assign result_taken = result_valid && !result_stall;
  assign new_mode     = state_next.mode;
  assign new_changed  = state_next.mode != state.mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blank_seconds    <= RESET_BLANK_SECONDS;
      cfg.sleep_seconds    <= RESET_SLEEP_SECONDS;
      cfg.check_cpu_enable <= 1'b0;
      cfg.cpu_busy_limit   <= RESET_BUSY_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLANK_SECONDS: cfg.blank_seconds    <= cfg_data;
        CFG_SLEEP_SECONDS: cfg.sleep_seconds    <= cfg_data;
        CFG_CHECK_CPU:     cfg.check_cpu_enable <= cfg_data[0];
        CFG_BUSY_LIMIT:    cfg.cpu_busy_limit   <= cfg_data[LOAD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_NORMAL;
      state.user_idle   <= 1'b0;
      state.blank_phase <= PH_UNARMED;
      state.blank_rem   <= '0;
      state.sleep_phase <= PH_UNARMED;
      state.sleep_rem   <= '0;
    end else if (item_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_taken) begin
        mode_now     <= skid_mode;
        mode_changed <= skid_changed;
        skid_valid   <= 1'b0;
      end
    end else if (item_accept) begin
      if (!result_valid || result_taken) begin
        mode_now     <= new_mode;
        mode_changed <= new_changed;
        result_valid <= 1'b1;
      end else begin
        skid_mode    <= new_mode;
        skid_changed <= new_changed;
        skid_valid   <= 1'b1;
      end
    end else if (result_taken) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/idbs_eval.sv]
`default_nettype none

module idbs_eval (
  input  idbs_pkg::idbs_state_t state_cur,
  input  idbs_pkg::idbs_cfg_t   cfg,
  input  idbs_pkg::cmd_t        command,
  input  idbs_pkg::idbs_flags_t flags,
  input  idbs_pkg::load_t       cpu_load,
  output idbs_pkg::idbs_state_t state_next
);
  import idbs_pkg::*;

  always_comb begin
    idbs_state_t s;
    logic blank_fire;
    logic sleep_fire;
    s          = state_cur;
    blank_fire = 1'b0;
    sleep_fire = 1'b0;

    unique case (command)
      CMD_TICK: begin
        if (s.blank_phase == PH_COUNTING) begin
          if (s.blank_rem[TIMER_BITS-1:1] == '0) begin
            blank_fire  = 1'b1;
            s.blank_rem = '0;
          end else begin
            s.blank_rem = s.blank_rem - count_t'(1);
          end
        end
        if (s.sleep_phase == PH_COUNTING) begin
          if (s.sleep_rem[TIMER_BITS-1:1] == '0) begin
            sleep_fire  = 1'b1;
            s.sleep_rem = '0;
          end else begin
            s.sleep_rem = s.sleep_rem - count_t'(1);
          end
        end
        if (blank_fire) begin
          s.blank_phase = PH_SPENT;
          if (s.mode != MODE_SLEEP) begin
            s.mode = MODE_BLANK;
          end
        end
        if (sleep_fire) begin
          if (cfg.check_cpu_enable && (cpu_load > cfg.cpu_busy_limit)) begin
            s.sleep_phase = PH_COUNTING;
            s.sleep_rem   = load_counter(cfg.sleep_seconds);
          end else begin
            s.sleep_phase = PH_SPENT;
            s.mode        = MODE_SLEEP;
          end
        end
      end
      CMD_ACTIVE: s.user_idle = 1'b0;
      CMD_IDLE:   s.user_idle = 1'b1;
      CMD_REEVAL: s.user_idle = state_cur.user_idle;
    endcase

    if (command != CMD_TICK) begin
      if (!s.user_idle || flags.idle_blocked) begin
        s.mode        = MODE_NORMAL;
        s.blank_phase = PH_UNARMED;
        s.blank_rem   = '0;
        s.sleep_phase = PH_UNARMED;
        s.sleep_rem   = '0;
      end else begin
        if (s.mode == MODE_NORMAL) begin
          s.mode = MODE_DIM;
        end
        if ((s.blank_phase == PH_UNARMED) && (cfg.blank_seconds != '0)) begin
          s.blank_phase = PH_COUNTING;
          s.blank_rem   = load_counter(cfg.blank_seconds);
        end
        if (flags.sleep_blocked) begin
          s.sleep_phase = PH_UNARMED;
          s.sleep_rem   = '0;
        end else if (flags.session_quiet) begin
          if ((s.sleep_phase == PH_UNARMED) && (cfg.sleep_seconds != '0)) begin
            s.sleep_phase = PH_COUNTING;
            s.sleep_rem   = load_counter(cfg.sleep_seconds);
          end
        end
      end
    end

    state_next = s;
  end

endmodule

`default_nettype wire

[rtl/core/idbs_checker.sv]
`default_nettype none

module idbs_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_stall,
  input logic            result_valid,
  input logic            result_stall,
  input idbs_pkg::mode_t mode_now,
  input logic            mode_changed
);
  import idbs_pkg::*;

  mode_t last_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= MODE_NORMAL;
    end else if (result_valid && !result_stall) begin
      last_mode <= mode_now;
    end
  end

  // The changed flag of each result must agree with the mode of the result before it.
  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mode_changed == (mode_now != last_mode)))
    else $error("mode_changed disagrees with the previous result");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result pending");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("result or stall present after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(mode_now) && $stable(mode_changed)))
    else $error("stalled result changed or vanished");

endmodule

bind idle_dim_blank_sleep_controller idbs_checker u_idbs_checker (.*);

`default_nettype wire
